>>> src/igb_pkg.sv
// ---------------------------------------------------------------------------
// igb_pkg: shared types, constants and helpers
// Sample format, rotation table, saturation and register index codes used by
// the gyro bias learner lanes, merge stage and bias unit.
// ---------------------------------------------------------------------------
package igb_pkg;

    localparam int S_W            = 24;
    localparam int STILL_INTERVAL = 10;
    localparam int SAVE_INTERVAL  = 6000;
    localparam int ROT_COUNT      = 24;
    localparam int TH_W           = 48;
    localparam int SQ_W           = 2 * S_W + 1;
    localparam int SUM_W          = SQ_W + 2;
    localparam int EXT_W          = S_W + 4;
    localparam int STILL_W        = 16;
    localparam int SAVE_W         = 24;
    localparam int ALPHA_W        = 16;
    localparam int MODE_W         = 3;
    localparam int CFG_IDX_W      = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_ROT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_TH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DGYRO_TH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_TH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_TH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_ALPHA  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ALPHA  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_MODE  = 3'd7;

    // learn mode bits
    localparam int MODE_LEARN = 0;
    localparam int MODE_MAN   = 1;
    localparam int MODE_SUB   = 2;

    typedef logic signed [S_W-1:0] t_smp;
    typedef logic signed [S_W:0]   t_dif;
    typedef logic [SQ_W-1:0]       t_sq;
    // lane source code: bit2 negate, bits1:0 source axis
    typedef logic [2:0]            t_rot_code;

    typedef struct packed {
        logic [ALPHA_W-1:0] fast_alpha;
        logic [ALPHA_W-1:0] slow_alpha;
        logic [TH_W-1:0]    bias_thresh;
        logic               mode_we;
        logic [MODE_W-1:0]  mode_data;
    } t_learn_cfg;

    localparam t_smp SMP_MAX = {1'b0, {(S_W-1){1'b1}}};
    localparam t_smp SMP_MIN = {1'b1, {(S_W-1){1'b0}}};

    function automatic t_smp sat_w(input logic signed [EXT_W-1:0] v);
        if (v > EXT_W'(SMP_MAX)) begin
            return SMP_MAX;
        end else if (v < EXT_W'(SMP_MIN)) begin
            return SMP_MIN;
        end
        return v[S_W-1:0];
    endfunction

    function automatic t_smp neg_sat(input t_smp v);
        if (v == SMP_MIN) begin
            return SMP_MAX;
        end
        return -v;
    endfunction

    // source code of one output lane for a rotation index
    function automatic t_rot_code rot_code(input logic [4:0] r, input logic [1:0] lane);
        logic [8:0] row;
        unique case (r)
            5'd1:    row = {3'd2, 3'd0, 3'd5};
            5'd2:    row = {3'd2, 3'd5, 3'd4};
            5'd3:    row = {3'd2, 3'd4, 3'd1};
            5'd4:    row = {3'd6, 3'd5, 3'd0};
            5'd5:    row = {3'd6, 3'd0, 3'd1};
            5'd6:    row = {3'd6, 3'd1, 3'd4};
            5'd7:    row = {3'd6, 3'd4, 3'd5};
            5'd8:    row = {3'd4, 3'd6, 3'd1};
            5'd9:    row = {3'd4, 3'd1, 3'd2};
            5'd10:   row = {3'd4, 3'd2, 3'd5};
            5'd11:   row = {3'd4, 3'd5, 3'd6};
            5'd12:   row = {3'd0, 3'd2, 3'd1};
            5'd13:   row = {3'd0, 3'd1, 3'd6};
            5'd14:   row = {3'd0, 3'd6, 3'd5};
            5'd15:   row = {3'd0, 3'd5, 3'd2};
            5'd16:   row = {3'd5, 3'd2, 3'd0};
            5'd17:   row = {3'd5, 3'd0, 3'd6};
            5'd18:   row = {3'd5, 3'd6, 3'd4};
            5'd19:   row = {3'd5, 3'd4, 3'd2};
            5'd20:   row = {3'd1, 3'd6, 3'd0};
            5'd21:   row = {3'd1, 3'd0, 3'd2};
            5'd22:   row = {3'd1, 3'd2, 3'd4};
            5'd23:   row = {3'd1, 3'd4, 3'd6};
            default: row = {3'd2, 3'd1, 3'd0};
        endcase
        if (32'(r) >= ROT_COUNT) begin
            row = {3'd2, 3'd1, 3'd0};
        end
        unique case (lane)
            2'd0:    return row[2:0];
            2'd1:    return row[5:3];
            default: return row[8:6];
        endcase
    endfunction

endpackage

>>> src/igb_lane.sv
// ---------------------------------------------------------------------------
// igb_lane: one axis lane
// Picks and signs the rotated component of gyro, accel and compass, forms the
// change against the previous sample and squares change and gyro terms.
// ---------------------------------------------------------------------------
module igb_lane import igb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  logic      i_adv2,
    input  t_rot_code i_code,
    input  t_smp      i_gyro [3],
    input  t_smp      i_accel [3],
    input  t_smp      i_mag [3],
    output t_smp      o_gyro,
    output t_smp      o_accel,
    output t_smp      o_mag,
    output t_sq       o_sq_da,
    output t_sq       o_sq_dg,
    output t_sq       o_sq_g
);

    t_smp n_gyro, n_accel, n_mag;
    t_smp r_prev_gyro, r_prev_accel;
    t_smp r_g1, r_a1, r_m1;
    t_dif r_da1, r_dg1;
    t_smp r_g2, r_a2, r_m2;
    t_sq  r_sq_da, r_sq_dg, r_sq_g;

    function automatic t_smp pick(input t_smp v [3], input t_rot_code c);
        t_smp s;
        unique case (c[1:0])
            2'd1:    s = v[1];
            2'd2:    s = v[2];
            default: s = v[0];
        endcase
        return c[2] ? neg_sat(s) : s;
    endfunction

    // rotation select
    always_comb begin
        n_gyro  = pick(i_gyro, i_code);
        n_accel = pick(i_accel, i_code);
        n_mag   = pick(i_mag, i_code);
    end

    // previous sample, kept in transaction order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_gyro  <= '0;
            r_prev_accel <= '0;
        end else if (i_load) begin
            r_prev_gyro  <= n_gyro;
            r_prev_accel <= n_accel;
        end
    end

    // stage 1: rotated values and changes
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_g1  <= n_gyro;
            r_a1  <= n_accel;
            r_m1  <= n_mag;
            r_da1 <= t_dif'(r_prev_accel) - t_dif'(n_accel);
            r_dg1 <= t_dif'(r_prev_gyro) - t_dif'(n_gyro);
        end
    end

    // stage 2: squares
    always_ff @(posedge i_clk) begin
        if (i_adv2) begin
            r_g2    <= r_g1;
            r_a2    <= r_a1;
            r_m2    <= r_m1;
            r_sq_da <= SQ_W'(r_da1 * r_da1);
            r_sq_dg <= SQ_W'(r_dg1 * r_dg1);
            r_sq_g  <= SQ_W'(t_dif'(r_g1) * t_dif'(r_g1));
        end
    end

    assign o_gyro  = r_g2;
    assign o_accel = r_a2;
    assign o_mag   = r_m2;
    assign o_sq_da = r_sq_da;
    assign o_sq_dg = r_sq_dg;
    assign o_sq_g  = r_sq_g;

endmodule

>>> src/igb_merge.sv
// ---------------------------------------------------------------------------
// igb_merge: motion decision
// Sums the lane squares into three squared lengths and compares them with
// the stillness thresholds.
// ---------------------------------------------------------------------------
module igb_merge import igb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_adv3,
    input  logic [TH_W-1:0] i_accel_th,
    input  logic [TH_W-1:0] i_dgyro_th,
    input  logic [TH_W-1:0] i_gyro_th,
    input  t_sq             i_sq_da [3],
    input  t_sq             i_sq_dg [3],
    input  t_sq             i_sq_g [3],
    input  t_smp            i_gyro [3],
    input  t_smp            i_accel [3],
    input  t_smp            i_mag [3],
    output logic            o_moving,
    output t_smp            o_gyro [3],
    output t_smp            o_accel [3],
    output t_smp            o_mag [3]
);

    logic [SUM_W-1:0] sum_da, sum_dg, sum_g;
    logic             n_moving;
    logic             r_moving;
    t_smp             r_gyro [3];
    t_smp             r_accel [3];
    t_smp             r_mag [3];

    // squared lengths and compare
    always_comb begin
        sum_da = SUM_W'(i_sq_da[0]) + SUM_W'(i_sq_da[1]) + SUM_W'(i_sq_da[2]);
        sum_dg = SUM_W'(i_sq_dg[0]) + SUM_W'(i_sq_dg[1]) + SUM_W'(i_sq_dg[2]);
        sum_g  = SUM_W'(i_sq_g[0]) + SUM_W'(i_sq_g[1]) + SUM_W'(i_sq_g[2]);
        n_moving = !((sum_da < SUM_W'(i_accel_th)) && (sum_dg < SUM_W'(i_dgyro_th)) &&
                     (sum_g < SUM_W'(i_gyro_th)));
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        if (i_adv3) begin
            r_moving <= n_moving;
            r_gyro   <= i_gyro;
            r_accel  <= i_accel;
            r_mag    <= i_mag;
        end
    end

    assign o_moving = r_moving;
    assign o_gyro   = r_gyro;
    assign o_accel  = r_accel;
    assign o_mag    = r_mag;

endmodule

>>> src/igb_bias.sv
// ---------------------------------------------------------------------------
// igb_bias: bias learning state
// Still-period candidate scheme, fast/slow exponential filters, save counter
// and bias subtraction of the outgoing gyro vector.
// ---------------------------------------------------------------------------
module igb_bias import igb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_commit,
    input  t_learn_cfg i_cfg,
    input  logic       i_moving,
    input  t_smp       i_gyro [3],
    output t_smp       o_gyro [3],
    output logic       o_moving,
    output logic       o_pulse
);

    localparam logic [STILL_W-1:0] STILL_CMP = STILL_W'(STILL_INTERVAL);
    localparam logic [SAVE_W-1:0]  SAVE_CMP  = SAVE_W'(SAVE_INTERVAL);

    t_smp              r_bias [3];
    t_smp              r_temp [3];
    t_smp              r_cand [3];
    logic              r_motion, r_started;
    logic [STILL_W-1:0] r_still_cnt;
    logic [SAVE_W-1:0]  r_save_cnt;
    logic [MODE_W-1:0]  r_mode;
    t_smp              r_out_g [3];
    t_smp              r_out_b [3];
    logic              r_out_sub, r_out_moving, r_out_pulse;

    t_smp              n_bias [3];
    t_smp              n_temp [3];
    t_smp              n_cand [3];
    t_smp              t0 [3];
    t_smp              b1 [3];
    t_smp              tf [3];
    t_smp              ts [3];
    t_smp              bm [3];
    t_dif              res [3];
    logic [SUM_W-1:0]  res_len;
    logic              n_started;
    logic [STILL_W-1:0] n_still_cnt, still_inc;
    logic [SAVE_W-1:0]  n_save_cnt, save_inc;
    logic [MODE_W-1:0]  n_mode;
    logic              n_pulse, trans, still_hit;

    function automatic t_smp blend(input t_smp t, input t_smp g, input logic [ALPHA_W-1:0] al);
        logic signed [S_W+ALPHA_W+1:0] p;
        logic signed [EXT_W-1:0]       q;
        p = (t_dif'(g) - t_dif'(t)) * $signed({1'b0, al});
        p = p + (S_W+ALPHA_W+2)'(32768);
        q = EXT_W'(p >>> 16);
        return sat_w(EXT_W'(t) + q);
    endfunction

    // next state of one transaction
    always_comb begin
        trans     = r_motion && !i_moving;
        n_started = trans ? 1'b1 : r_started;
        n_still_cnt = trans ? '0 : r_still_cnt;
        still_inc = n_still_cnt + 1'b1;
        still_hit = r_mode[MODE_LEARN] && !i_moving && (still_inc >= STILL_CMP);
        for (int i = 0; i < 3; i++) begin
            t0[i] = trans ? r_bias[i] : r_temp[i];
            n_cand[i] = trans ? r_bias[i] : r_cand[i];
            b1[i] = r_bias[i];
            res[i] = t_dif'(i_gyro[i]) - t_dif'(t0[i]);
            tf[i] = blend(t0[i], i_gyro[i], i_cfg.fast_alpha);
            ts[i] = blend(t0[i], i_gyro[i], i_cfg.slow_alpha);
        end
        res_len = SUM_W'(SQ_W'(res[0] * res[0])) + SUM_W'(SQ_W'(res[1] * res[1])) +
                  SUM_W'(SQ_W'(res[2] * res[2]));
        for (int i = 0; i < 3; i++) begin
            n_temp[i] = t0[i];
        end
        // still-period learning
        if (r_mode[MODE_LEARN] && !i_moving) begin
            n_still_cnt = still_inc;
            if (still_hit) begin
                n_still_cnt = '0;
                n_started   = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    b1[i]     = n_cand[i];
                    n_cand[i] = t0[i];
                end
            end
            if (!n_started) begin
                for (int i = 0; i < 3; i++) begin
                    n_temp[i] = (res_len > SUM_W'(i_cfg.bias_thresh)) ? tf[i] : ts[i];
                end
            end
        end
        // periodic save
        n_mode     = r_mode;
        n_pulse    = 1'b0;
        save_inc   = r_save_cnt + 1'b1;
        n_save_cnt = r_save_cnt;
        if (r_mode[MODE_LEARN]) begin
            n_save_cnt = save_inc;
            if (save_inc >= SAVE_CMP) begin
                n_save_cnt       = '0;
                n_mode[MODE_SUB] = 1'b1;
                n_pulse          = 1'b1;
            end
        end
        // manual averaging
        for (int i = 0; i < 3; i++) begin
            bm[i]     = blend(b1[i], i_gyro[i], i_cfg.fast_alpha);
            n_bias[i] = r_mode[MODE_MAN] ? bm[i] : b1[i];
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion    <= 1'b1;
            r_started   <= 1'b0;
            r_still_cnt <= '0;
            r_save_cnt  <= '0;
            r_mode      <= 3'd5;
            for (int i = 0; i < 3; i++) begin
                r_bias[i] <= '0;
                r_temp[i] <= '0;
                r_cand[i] <= '0;
            end
        end else if (i_cfg.mode_we) begin
            r_mode <= i_cfg.mode_data;
        end else if (i_commit) begin
            r_motion    <= i_moving;
            r_started   <= n_started;
            r_still_cnt <= n_still_cnt;
            r_save_cnt  <= n_save_cnt;
            r_mode      <= n_mode;
            r_bias      <= n_bias;
            r_temp      <= n_temp;
            r_cand      <= n_cand;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_out_g      <= i_gyro;
            r_out_b      <= n_bias;
            r_out_sub    <= n_mode[MODE_SUB];
            r_out_moving <= i_moving;
            r_out_pulse  <= n_pulse;
        end
    end

    // bias subtraction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_gyro[i] = r_out_sub ? sat_w(EXT_W'(r_out_g[i]) - EXT_W'(r_out_b[i])) : r_out_g[i];
        end
    end

    assign o_moving = r_out_moving;
    assign o_pulse  = r_out_pulse;

endmodule

>>> src/imu_gyro_bias_learner.sv
// ---------------------------------------------------------------------------
// imu_gyro_bias_learner: 9-axis sample rotation and gyro bias learning
// Top level: input and output channels, configuration registers and the
// pipeline valid chain.
// ---------------------------------------------------------------------------
// Usage:
//  - input channel i_valid / o_stall carries one 9-axis sample per
//    transaction; output channel o_valid / i_stall carries the rotated,
//    bias-corrected sample plus the moving flag and save pulse
//  - one sample per cycle sustained while the receiver does not stall; four
//    register stages (rotate/delta, squares, motion compare, bias state
//    update), and o_valid is the valid flag of the last stage
//  - config writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once;
//    write only while no sample is in flight
//  - reset: thresholds 0, alphas 1311 / 13, learn mode 5, rotation 0,
//    all bias and history state cleared, motion flag set to moving
//  - when the receiver stalls, the result holds on the output and the
//    pipeline keeps accepting until its empty stages are filled, then
//    o_stall rises
// ---------------------------------------------------------------------------
module imu_gyro_bias_learner import igb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_smp                 i_gyro_x,
    input  t_smp                 i_gyro_y,
    input  t_smp                 i_gyro_z,
    input  t_smp                 i_accel_x,
    input  t_smp                 i_accel_y,
    input  t_smp                 i_accel_z,
    input  t_smp                 i_mag_x,
    input  t_smp                 i_mag_y,
    input  t_smp                 i_mag_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_smp                 o_out_gyro_x,
    output t_smp                 o_out_gyro_y,
    output t_smp                 o_out_gyro_z,
    output t_smp                 o_out_accel_x,
    output t_smp                 o_out_accel_y,
    output t_smp                 o_out_accel_z,
    output t_smp                 o_out_mag_x,
    output t_smp                 o_out_mag_y,
    output t_smp                 o_out_mag_z,
    output logic                 o_moving,
    output logic                 o_save_pulse,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TH_W-1:0]      i_cfg_data
);

    logic [4:0]         r_axis_rot;
    logic [TH_W-1:0]    r_accel_th, r_dgyro_th, r_gyro_th, r_bias_th;
    logic [ALPHA_W-1:0] r_fast_alpha, r_slow_alpha;
    logic               r_v1, r_v2, r_v3, r_v4;
    logic               en1, en2, en3, en4, load, commit;
    t_learn_cfg         learn_cfg;
    t_smp               in_g [3];
    t_smp               in_a [3];
    t_smp               in_m [3];
    t_smp               l_g [3];
    t_smp               l_a [3];
    t_smp               l_m [3];
    t_sq                sq_da [3];
    t_sq                sq_dg [3];
    t_sq                sq_g [3];
    logic               m_moving;
    t_smp               m_g [3];
    t_smp               m_a [3];
    t_smp               m_m [3];
    t_smp               b_g [3];
    t_smp               r_out_a [3];
    t_smp               r_out_m [3];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_rot   <= '0;
            r_accel_th   <= '0;
            r_dgyro_th   <= '0;
            r_gyro_th    <= '0;
            r_bias_th    <= '0;
            r_fast_alpha <= 16'd1311;
            r_slow_alpha <= 16'd13;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AXIS_ROT:   r_axis_rot   <= i_cfg_data[4:0];
                CFG_ACCEL_TH:   r_accel_th   <= i_cfg_data;
                CFG_DGYRO_TH:   r_dgyro_th   <= i_cfg_data;
                CFG_GYRO_TH:    r_gyro_th    <= i_cfg_data;
                CFG_BIAS_TH:    r_bias_th    <= i_cfg_data;
                CFG_FAST_ALPHA: r_fast_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_SLOW_ALPHA: r_slow_alpha <= i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    assign learn_cfg = '{fast_alpha:  r_fast_alpha,
                         slow_alpha:  r_slow_alpha,
                         bias_thresh: r_bias_th,
                         mode_we:     i_cfg_we && (i_cfg_idx == CFG_LEARN_MODE),
                         mode_data:   i_cfg_data[MODE_W-1:0]};

    // pipeline advance, stages fill bubbles independently
    assign en4     = !r_v4 || !i_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign load    = i_valid && en1;
    assign commit  = r_v3 && en4;
    assign o_stall = !en1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    assign in_g = '{i_gyro_x, i_gyro_y, i_gyro_z};
    assign in_a = '{i_accel_x, i_accel_y, i_accel_z};
    assign in_m = '{i_mag_x, i_mag_y, i_mag_z};

    // axis lanes
    for (genvar k = 0; k < 3; k++) begin : g_lane
        igb_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (load),
            .i_adv2  (en2),
            .i_code  (rot_code(r_axis_rot, 2'(k))),
            .i_gyro  (in_g),
            .i_accel (in_a),
            .i_mag   (in_m),
            .o_gyro  (l_g[k]),
            .o_accel (l_a[k]),
            .o_mag   (l_m[k]),
            .o_sq_da (sq_da[k]),
            .o_sq_dg (sq_dg[k]),
            .o_sq_g  (sq_g[k])
        );
    end

    igb_merge u_merge (
        .i_clk      (i_clk),
        .i_adv3     (en3),
        .i_accel_th (r_accel_th),
        .i_dgyro_th (r_dgyro_th),
        .i_gyro_th  (r_gyro_th),
        .i_sq_da    (sq_da),
        .i_sq_dg    (sq_dg),
        .i_sq_g     (sq_g),
        .i_gyro     (l_g),
        .i_accel    (l_a),
        .i_mag      (l_m),
        .o_moving   (m_moving),
        .o_gyro     (m_g),
        .o_accel    (m_a),
        .o_mag      (m_m)
    );

    igb_bias u_bias (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_cfg    (learn_cfg),
        .i_moving (m_moving),
        .i_gyro   (m_g),
        .o_gyro   (b_g),
        .o_moving (o_moving),
        .o_pulse  (o_save_pulse)
    );

    // accel and compass output registers
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_a <= m_a;
            r_out_m <= m_m;
        end
    end

    assign o_out_gyro_x  = b_g[0];
    assign o_out_gyro_y  = b_g[1];
    assign o_out_gyro_z  = b_g[2];
    assign o_out_accel_x = r_out_a[0];
    assign o_out_accel_y = r_out_a[1];
    assign o_out_accel_z = r_out_a[2];
    assign o_out_mag_x   = r_out_m[0];
    assign o_out_mag_y   = r_out_m[1];
    assign o_out_mag_z   = r_out_m[2];

endmodule

>>> src/igb_checker.sv
// ---------------------------------------------------------------------------
// igb_checker: port-level checks
// Watches the top level ports for handshake and pipeline behavior.
// ---------------------------------------------------------------------------
module igb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input logic o_stall,
    input logic o_moving
);

    // a stalled result stays valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output transaction dropped under stall");

    // a stalled result keeps its flag
    a_hold_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_moving))
        else $error("output changed under stall");

    // an empty output never backs up the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) && i_rst_n |-> !o_valid)
        else $error("output valid after reset");

endmodule

bind imu_gyro_bias_learner igb_checker u_igb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_stall  (o_stall),
    .o_moving (o_moving)
);
